@@ hw/rtl/cse_pkg.sv @@
// Shared types and constants for the centered score engine.
// No dependencies; imported by cse_score_unit and centered_score_engine_core.
`timescale 1ns / 1ps

package cse_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int RESP_W       = 32;
  localparam int TOTAL_W      = 38;
  localparam int PROD_W       = CNT_W + 1 + RESP_W;
  localparam int DIFF_W       = PROD_W + 1;
  localparam int SCORE_W      = 39;

  // register indexes on the configuration port
  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_STEP  = 2'd1;
  localparam logic [1:0] REG_MODE  = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_BAD_CFG  = 2'd2;

  localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(2);
  localparam logic [RESP_W-1:0] STEP_RESET  = RESP_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_EMIT
  } cse_state_t;

  // sequencer to score unit
  typedef struct packed {
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic signed [RESP_W-1:0]   wr_data;
    logic                       rd_en;
    logic [IDX_W-1:0]           rd_addr;
    logic [CNT_W-1:0]           count;
    logic signed [TOTAL_W-1:0]  total;
  } cse_ctrl_t;

  // score unit back to sequencer
  typedef struct packed {
    logic                       valid;
    logic [IDX_W-1:0]           index;
    logic signed [DIFF_W-1:0]   value;
    logic                       pipe_busy;
  } cse_sts_t;

endpackage

@@ hw/rtl/cse_score_unit.sv @@
// Response store and shared score datapath: read, multiply by count, subtract total.
// Depends on cse_pkg for the control and status structs.
`timescale 1ns / 1ps

module cse_score_unit
  import cse_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cse_ctrl_t ctrl,
  output cse_sts_t  sts
);

  logic signed [RESP_W-1:0] mem [MAX_ELEMENTS];
  logic signed [RESP_W-1:0] rd_data_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DIFF_W-1:0] score_r;
  logic [IDX_W-1:0]         idx1_r, idx2_r, idx3_r;
  logic                     v1_r, v2_r, v3_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [DIFF_W-1:0] score_nxt;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= ctrl.wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data_r <= mem[ctrl.rd_addr];
    end
  end

  assign prod_nxt  = {{(PROD_W-CNT_W){1'b0}}, ctrl.count}
                   * {{(PROD_W-RESP_W){rd_data_r[RESP_W-1]}}, rd_data_r};
  assign score_nxt = {prod_r[PROD_W-1], prod_r}
                   - {{(DIFF_W-TOTAL_W){ctrl.total[TOTAL_W-1]}}, ctrl.total};

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    score_r <= score_nxt;
    idx1_r  <= ctrl.rd_addr;
    idx2_r  <= idx1_r;
    idx3_r  <= idx2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= ctrl.rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign sts.valid     = v3_r;
  assign sts.index     = idx3_r;
  assign sts.value     = score_r;
  assign sts.pipe_busy = v1_r | v2_r | v3_r;

endmodule

@@ hw/rtl/centered_score_engine_core.sv @@
// Top level of the centered score engine: configuration, sequencer, result registers.
// Depends on cse_pkg and cse_score_unit.
//
//   channel | ports                            | transfer
//   --------+----------------------------------+------------------------------
//   input   | start, busy, in_response_value   | start high while busy low
//   result  | out_strobe, out_*                | each cycle out_strobe is high
//   config  | cfg_valid, cfg_ready, cfg_index, | cfg_valid and cfg_ready high
//           | cfg_data                         |
//
// A response that does not complete its set is accepted and then stored.
// The response that completes a set of n then runs a check pass (checked mode
// only) and, unless the check finds an overflow, an emit pass over the store, each
// through the shared read / multiply / subtract pipeline; scores leave one per cycle.
// Reset clears the sequencer and loads the register reset values; no clearing
// pass. Results cannot be stalled; cfg_ready is always high.
`timescale 1ns / 1ps

module centered_score_engine_core
  import cse_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [RESP_W-1:0]  in_response_value,
  output logic                      out_strobe,
  output logic [IDX_W-1:0]          out_score_index,
  output logic signed [SCORE_W-1:0] out_score_value,
  output logic signed [TOTAL_W-1:0] out_total_value,
  output logic                      out_total_fits,
  output logic [1:0]                out_status_code,
  output logic                      out_last_of_run,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [31:0]               cfg_data
);

  cse_state_t state_r, state_nxt;

  logic [CNT_W-1:0]          count_r;
  logic signed [RESP_W-1:0]  step_r;
  logic                      wide_r;
  logic                      cfg_ok_r;
  logic signed [RESP_W-1:0]  resp_r;
  logic [CNT_W-1:0]          loaded_r;
  logic signed [TOTAL_W-1:0] total_r;
  logic [CNT_W-1:0]          iss_r;
  logic                      ovf_r;

  logic                      out_strobe_r;
  logic [IDX_W-1:0]          out_index_r;
  logic signed [SCORE_W-1:0] out_score_r;
  logic signed [TOTAL_W-1:0] out_total_r;
  logic                      out_fits_r;
  logic [1:0]                out_status_r;
  logic                      out_last_r;

  cse_ctrl_t ctrl;
  cse_sts_t  sts;

  logic                      cfg_wr;
  logic                      cfg_restart;
  logic                      accept;
  logic signed [PROD_W-1:0]  hot;
  logic                      cfg_ok_nxt;
  logic                      total_fits;
  logic                      score_fits;
  logic                      set_done, finish, emit_bad, emit_ovf, iss_clr, iss_inc;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  // only a write to a listed register restarts the set
  assign cfg_restart = cfg_wr && (cfg_index inside {REG_COUNT, REG_STEP, REG_MODE});
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start & ~busy;

  // configuration check, registered every cycle
  assign hot = {{(PROD_W-CNT_W){1'b0}}, count_r - CNT_W'(1)}
             * {{(PROD_W-RESP_W){step_r[RESP_W-1]}}, step_r};
  assign cfg_ok_nxt = (count_r >= CNT_W'(2)) && (count_r <= CNT_W'(MAX_ELEMENTS))
                    && (step_r != '0) && (step_r != {1'b1, {(RESP_W-1){1'b0}}})
                    && ((&hot[PROD_W-1:RESP_W-1]) || !(|hot[PROD_W-1:RESP_W-1]));

  assign total_fits = (&total_r[TOTAL_W-1:RESP_W-1]) || !(|total_r[TOTAL_W-1:RESP_W-1]);
  assign score_fits = (&sts.value[DIFF_W-1:RESP_W-1]) || !(|sts.value[DIFF_W-1:RESP_W-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= COUNT_RESET;
      step_r   <= STEP_RESET;
      wide_r   <= 1'b0;
      cfg_ok_r <= 1'b1;
    end else begin
      cfg_ok_r <= cfg_ok_nxt;
      if (cfg_wr) begin
        case (cfg_index)
          REG_COUNT: count_r <= cfg_data[CNT_W-1:0];
          REG_STEP:  step_r  <= cfg_data;
          REG_MODE:  wide_r  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    set_done     = 1'b0;
    finish       = 1'b0;
    emit_bad     = 1'b0;
    emit_ovf     = 1'b0;
    iss_clr      = 1'b0;
    iss_inc      = 1'b0;
    ctrl.wr_en   = 1'b0;
    ctrl.wr_addr = loaded_r[IDX_W-1:0];
    ctrl.wr_data = resp_r;
    ctrl.rd_en   = 1'b0;
    ctrl.rd_addr = iss_r[IDX_W-1:0];
    ctrl.count   = count_r;
    ctrl.total   = total_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!cfg_ok_r) begin
          emit_bad  = 1'b1;
          finish    = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          ctrl.wr_en = 1'b1;
          if (loaded_r + CNT_W'(1) >= count_r) begin
            set_done  = 1'b1;
            state_nxt = wide_r ? ST_EMIT : ST_CHECK;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_CHECK: begin
        if (iss_r != count_r) begin
          ctrl.rd_en = 1'b1;
          iss_inc    = 1'b1;
        end else if (!sts.pipe_busy) begin
          if (ovf_r) begin
            emit_ovf  = 1'b1;
            finish    = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            iss_clr   = 1'b1;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (iss_r != count_r) begin
          ctrl.rd_en = 1'b1;
          iss_inc    = 1'b1;
        end else if (!sts.pipe_busy) begin
          finish    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      resp_r <= in_response_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
      total_r  <= '0;
      iss_r    <= '0;
      ovf_r    <= 1'b0;
    end else begin
      if (cfg_restart || finish) begin
        loaded_r <= '0;
        total_r  <= '0;
      end else if (ctrl.wr_en) begin
        loaded_r <= loaded_r + CNT_W'(1);
        total_r  <= total_r + {{(TOTAL_W-RESP_W){resp_r[RESP_W-1]}}, resp_r};
      end
      if (set_done || iss_clr) begin
        iss_r <= '0;
      end else if (iss_inc) begin
        iss_r <= iss_r + CNT_W'(1);
      end
      // latch any score that leaves the 32-bit range during the check pass
      if (set_done) begin
        ovf_r <= 1'b0;
      end else if (state_r == ST_CHECK && sts.valid && !score_fits) begin
        ovf_r <= 1'b1;
      end
    end
  end

  cse_score_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .sts   (sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= emit_bad | emit_ovf | (state_r == ST_EMIT && sts.valid);
    end
  end

  always_ff @(posedge clk) begin
    if (emit_bad) begin
      out_index_r  <= '0;
      out_score_r  <= '0;
      out_total_r  <= '0;
      out_fits_r   <= 1'b0;
      out_status_r <= STATUS_BAD_CFG;
      out_last_r   <= 1'b1;
    end else if (emit_ovf) begin
      out_index_r  <= '0;
      out_score_r  <= '0;
      out_total_r  <= total_r;
      out_fits_r   <= total_fits;
      out_status_r <= STATUS_OVERFLOW;
      out_last_r   <= 1'b1;
    end else begin
      out_index_r  <= sts.index;
      out_score_r  <= sts.value[SCORE_W-1:0];
      out_total_r  <= total_r;
      out_fits_r   <= total_fits;
      out_status_r <= STATUS_OK;
      out_last_r   <= ({1'b0, sts.index} == count_r - CNT_W'(1));
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_score_index = out_index_r;
  assign out_score_value = out_score_r;
  assign out_total_value = out_total_r;
  assign out_total_fits  = out_fits_r;
  assign out_status_code = out_status_r;
  assign out_last_of_run = out_last_r;

`ifndef SYNTHESIS
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status_code != STATUS_OK) |-> out_last_of_run)
    else $error("error result not marked last");

  a_ovf_checked_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status_code == STATUS_OVERFLOW) |-> !wide_r)
    else $error("overflow result in wide mode");

  a_quiet_in_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> !out_strobe)
    else $error("result emitted during check pass");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status_code == STATUS_OK && out_last_of_run)
      |-> ({1'b0, out_score_index} == count_r - CNT_W'(1)))
    else $error("last score at wrong index");

  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (loaded_r < CNT_W'(MAX_ELEMENTS)))
    else $error("store fill beyond depth while idle");
`endif

endmodule

@@ tb/sv/tb_centered_score_engine_core.sv @@
// Self-checking testbench for centered_score_engine_core: directed table, then random sets.
// Depends on cse_pkg and the RTL of centered_score_engine_core; scores come from a local predictor.
`timescale 1ns / 1ps

module tb_centered_score_engine_core;
  import cse_pkg::*;

  localparam int RANDOM_ITEMS   = 290;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PLAN_LEN       = 39;

  // index past the register list; a write there must change nothing
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;
  typedef enum int {MAG_SMALL, MAG_MEDIUM, MAG_FULL, MAG_CORNER} mag_t;

  typedef struct packed {
    logic [IDX_W-1:0]          idx;
    logic signed [SCORE_W-1:0] score;
    logic signed [TOTAL_W-1:0] total;
    logic                      fits;
    logic [1:0]                status;
    logic                      last;
  } score_rec_t;

  // typed rows carry a single error result: index 0, score 0, last set
  typedef struct packed {
    row_kind_t                 kind;
    logic [1:0]                reg_idx;
    logic [31:0]               data;
    logic                      typed;
    logic [1:0]                status;
    logic signed [TOTAL_W-1:0] total;
    logic                      fits;
  } row_t;

  row_t plan_rows [PLAN_LEN] = '{
    '{ROW_ITEM,  REG_COUNT, 32'h0000_0005, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_ITEM,  REG_COUNT, 32'h0000_0007, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_ITEM,  REG_COUNT, 32'h7FFF_FFFF, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_ITEM,  REG_COUNT, 32'h8000_0000, 1'b1, STATUS_OVERFLOW, -38'sd1,          1'b1},
    '{ROW_WRITE, REG_MODE,  32'h0000_0001, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_ITEM,  REG_COUNT, 32'h7FFF_FFFF, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_ITEM,  REG_COUNT, 32'h8000_0000, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_WRITE, REG_COUNT, 32'h0000_0003, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_ITEM,  REG_COUNT, 32'h7FFF_FFFF, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_ITEM,  REG_COUNT, 32'h7FFF_FFFF, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_ITEM,  REG_COUNT, 32'h7FFF_FFFF, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_WRITE, REG_MODE,  32'h0000_0000, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_ITEM,  REG_COUNT, 32'h8000_0000, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_ITEM,  REG_COUNT, 32'h8000_0000, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_ITEM,  REG_COUNT, 32'h7FFF_FFFF, 1'b1, STATUS_OVERFLOW, -38'sd2147483649, 1'b0},
    '{ROW_WRITE, REG_COUNT, 32'h0000_0000, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_ITEM,  REG_COUNT, 32'h1234_5678, 1'b1, STATUS_BAD_CFG,  '0,               1'b0},
    '{ROW_WRITE, REG_COUNT, 32'h0000_0001, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_ITEM,  REG_COUNT, 32'h0000_0000, 1'b1, STATUS_BAD_CFG,  '0,               1'b0},
    '{ROW_WRITE, REG_COUNT, 32'h0000_0041, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_ITEM,  REG_COUNT, 32'hFFFF_FFFF, 1'b1, STATUS_BAD_CFG,  '0,               1'b0},
    '{ROW_WRITE, REG_COUNT, 32'h0000_007F, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_ITEM,  REG_COUNT, 32'h5555_5555, 1'b1, STATUS_BAD_CFG,  '0,               1'b0},
    '{ROW_WRITE, REG_COUNT, 32'h0000_0002, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_WRITE, REG_STEP,  32'h0000_0000, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_ITEM,  REG_COUNT, 32'hAAAA_AAAA, 1'b1, STATUS_BAD_CFG,  '0,               1'b0},
    '{ROW_WRITE, REG_STEP,  32'h8000_0000, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_ITEM,  REG_COUNT, 32'h0000_0001, 1'b1, STATUS_BAD_CFG,  '0,               1'b0},
    '{ROW_WRITE, REG_STEP,  32'h7FFF_FFFF, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_ITEM,  REG_COUNT, 32'h0000_0001, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_ITEM,  REG_COUNT, 32'hFFFF_FFFF, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_WRITE, REG_COUNT, 32'h0000_0003, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_ITEM,  REG_COUNT, 32'h0000_0003, 1'b1, STATUS_BAD_CFG,  '0,               1'b0},
    '{ROW_WRITE, REG_COUNT, 32'h0000_0002, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_WRITE, REG_STEP,  32'h8000_0001, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_ITEM,  REG_COUNT, 32'h0000_000A, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_WRITE, REG_SPARE, 32'h0000_0000, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_ITEM,  REG_COUNT, 32'h0000_0014, 1'b0, STATUS_OK,       '0,               1'b0},
    '{ROW_WRITE, REG_STEP,  32'h0000_0001, 1'b0, STATUS_OK,       '0,               1'b0}
  };

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic signed [RESP_W-1:0]  in_response_value;
  logic                      out_strobe;
  logic [IDX_W-1:0]          out_score_index;
  logic signed [SCORE_W-1:0] out_score_value;
  logic signed [TOTAL_W-1:0] out_total_value;
  logic                      out_total_fits;
  logic [1:0]                out_status_code;
  logic                      out_last_of_run;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [1:0]                cfg_index;
  logic [31:0]               cfg_data;

  // predictor copy of the registers and the set in progress
  logic [CNT_W-1:0]          exp_count;
  logic signed [31:0]        exp_step;
  logic                      exp_wide;
  int                        exp_loaded;
  longint                    exp_total;
  logic signed [31:0]        exp_store [MAX_ELEMENTS];

  score_rec_t                pending_scores[$];
  score_rec_t                fresh_scores[$];
  score_rec_t                head_score;
  int                        mismatches = 0;
  int                        idle_cycles = 0;
  bit                        cfg_held = 1'b0;

  centered_score_engine_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_response_value (in_response_value),
    .out_strobe        (out_strobe),
    .out_score_index   (out_score_index),
    .out_score_value   (out_score_value),
    .out_total_value   (out_total_value),
    .out_total_fits    (out_total_fits),
    .out_status_code   (out_status_code),
    .out_last_of_run   (out_last_of_run),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit fits_word(longint v);
    return v >= -64'sd2147483648 && v <= 64'sd2147483647;
  endfunction

  function automatic bit setup_is_legal();
    longint n;
    longint s;
    n = exp_count;
    s = exp_step;
    if (n < 2 || n > MAX_ELEMENTS) return 1'b0;
    if (s == 0 || s == -64'sd2147483648) return 1'b0;
    return fits_word((n - 1) * s);
  endfunction

  function automatic void load_register(logic [1:0] idx, logic [31:0] data);
    case (idx)
      REG_COUNT: exp_count = data[CNT_W-1:0];
      REG_STEP:  exp_step  = data;
      REG_MODE:  exp_wide  = data[0];
      default:   return;
    endcase
    // any real register write restarts the set
    exp_loaded = 0;
    exp_total  = 0;
  endfunction

  // fills fresh_scores with what one accepted response should produce
  function automatic void predict_scores(logic signed [31:0] resp);
    longint     n;
    longint     total;
    bit         over;
    int         i;
    score_rec_t r;
    fresh_scores.delete();
    r = '0;
    r.last = 1'b1;
    if (!setup_is_legal()) begin
      exp_loaded = 0;
      exp_total  = 0;
      r.status   = STATUS_BAD_CFG;
      fresh_scores.push_back(r);
      return;
    end
    exp_store[exp_loaded % MAX_ELEMENTS] = resp;
    exp_total += resp;
    exp_loaded++;
    if (exp_loaded < exp_count) return;

    total      = exp_total;
    n          = exp_count;
    exp_loaded = 0;
    exp_total  = 0;
    r.total    = TOTAL_W'(total);
    r.fits     = fits_word(total);
    if (!exp_wide) begin
      over = 1'b0;
      for (i = 0; i < n; i++) begin
        if (!fits_word(n * exp_store[i] - total)) over = 1'b1;
      end
      if (over) begin
        r.status = STATUS_OVERFLOW;
        fresh_scores.push_back(r);
        return;
      end
    end
    for (i = 0; i < n; i++) begin
      r.idx    = IDX_W'(i);
      r.score  = SCORE_W'(n * exp_store[i] - total);
      r.status = STATUS_OK;
      r.last   = (i == n - 1);
      fresh_scores.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 70) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic [31:0] pick_response(mag_t m);
    logic [31:0] w;
    int          t;
    w = $urandom;
    case (m)
      MAG_SMALL: begin
        t = $urandom_range(2000, 0);
        return t - 1000;
      end
      MAG_MEDIUM: return {{8{w[23]}}, w[23:0]};
      MAG_CORNER: begin
        case ($urandom_range(4, 0))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      default: return w;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    int r;
    int v;
    r = $urandom_range(99, 0);
    if (r < 55) v = $urandom_range(6, 2);
    else if (r < 72) v = $urandom_range(20, 7);
    else if (r < 84) v = MAX_ELEMENTS;
    else if (r < 90) v = 2;
    else if (r < 94) v = $urandom_range(63, 21);
    else begin
      case ($urandom_range(2, 0))
        0:       v = 0;
        1:       v = 1;
        default: v = $urandom_range(127, 65);
      endcase
    end
    return CNT_W'(v);
  endfunction

  // mostly a step that keeps (count - 1) * step in range, sometimes any word
  function automatic logic [31:0] pick_step(longint n);
    longint lim;
    longint s;
    int     r;
    r = $urandom_range(99, 0);
    if (n < 2 || n > MAX_ELEMENTS || r < 8) return $urandom;
    lim = 64'sd2147483647 / (n - 1);
    if (r < 20) s = lim;
    else s = (longint'($urandom) % lim) + 1;
    if ($urandom_range(1, 0) == 1) s = -s;
    return s[31:0];
  endfunction

  // drop start and cfg_valid, hold until every expected result is in
  task automatic quiesce(int extra);
    start     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_held   = 1'b0;
    do @(posedge clk); while (pending_scores.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no second drive in one step
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_held   = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    load_register(idx, data);
  endtask

  // returns at the edge of the transfer, start still high
  task automatic put_item(logic [31:0] value, int gap);
    if (cfg_held) begin
      cfg_valid <= 1'b0;
      cfg_held   = 1'b0;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_response_value <= value;
    do @(posedge clk); while (busy);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_scores.size() == 0) begin
        $error("unexpected result: score_index %0d status_code %0d",
               out_score_index, out_status_code);
        mismatches++;
      end else begin
        head_score = pending_scores.pop_front();
        check_field("score_index", head_score.idx, out_score_index);
        check_field("score_value", $signed(head_score.score), $signed(out_score_value));
        check_field("total_value", $signed(head_score.total), $signed(out_total_value));
        check_field("total_fits", head_score.fits, out_total_fits);
        check_field("status_code", head_score.status, out_status_code);
        check_field("last_of_run", head_score.last, out_last_of_run);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL centered_score_engine_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    row_t             row;
    score_rec_t       typed_rec;
    int               i;
    int               k;
    int               burst;
    int               random_sent;
    logic [31:0]      value;
    logic [31:0]      step;
    logic [31:0]      junk;
    logic [CNT_W-1:0] count;
    logic             wide;
    mag_t             profile;
    bit               calm;

    rst_n             <= 1'b0;
    start             <= 1'b0;
    in_response_value <= '0;
    cfg_valid         <= 1'b0;
    cfg_index         <= REG_COUNT;
    cfg_data          <= '0;
    exp_count          = COUNT_RESET;
    exp_step           = STEP_RESET;
    exp_wide           = 1'b0;
    exp_loaded         = 0;
    exp_total          = 0;
    random_sent        = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < PLAN_LEN; i++) begin
      row = plan_rows[i];
      if (row.kind == ROW_WRITE) begin
        if (i == 0 || plan_rows[i-1].kind != ROW_WRITE) quiesce(SETTLE_CYCLES);
        write_reg(row.reg_idx, row.data);
      end else begin
        put_item(row.data, pick_gap());
        // run the predictor on every row so its set state stays in step
        predict_scores(row.data);
        if (row.typed) begin
          typed_rec        = '0;
          typed_rec.total  = row.total;
          typed_rec.fits   = row.fits;
          typed_rec.status = row.status;
          typed_rec.last   = 1'b1;
          pending_scores.push_back(typed_rec);
        end else begin
          for (k = 0; k < fresh_scores.size(); k++) pending_scores.push_back(fresh_scores[k]);
        end
      end
    end

    while (random_sent < RANDOM_ITEMS) begin
      count = pick_count();
      step  = pick_step(count);
      wide  = 1'($urandom_range(1, 0));
      quiesce(SETTLE_CYCLES);
      junk = ($urandom_range(3, 0) == 0) ? $urandom : 32'd0;
      write_reg(REG_COUNT, {junk[31:CNT_W], count});
      write_reg(REG_STEP, step);
      junk = ($urandom_range(3, 0) == 0) ? $urandom : 32'd0;
      write_reg(REG_MODE, {junk[31:1], wide});
      if ($urandom_range(7, 0) == 0) write_reg(REG_SPARE, $urandom);

      if (!setup_is_legal()) burst = 3;
      else if (count == MAX_ELEMENTS) burst = MAX_ELEMENTS;
      else begin
        burst = int'(count) * $urandom_range(3, 1);
        // a partial set left behind gets restarted by the next phase's writes
        if ($urandom_range(3, 0) == 0) burst += $urandom_range(count - 1, 1);
      end
      profile = mag_t'($urandom_range(3, 0));
      calm    = ($urandom_range(3, 0) == 0);

      for (k = 0; k < burst && random_sent < RANDOM_ITEMS; k++) begin
        if (random_sent == 7 || $urandom_range(39, 0) == 0) quiesce(0);
        value = pick_response(($urandom_range(9, 0) == 0) ? MAG_CORNER : profile);
        put_item(value, calm ? 0 : pick_gap());
        predict_scores(value);
        for (i = 0; i < fresh_scores.size(); i++) pending_scores.push_back(fresh_scores[i]);
        random_sent++;
      end
    end

    quiesce(DRAIN_CYCLES);
    if (mismatches == 0) begin
      $display("PASS centered_score_engine_core");
    end else begin
      $display("FAIL centered_score_engine_core");
    end
    $finish;
  end

endmodule

@@ centered_score_engine_core.f @@
hw/rtl/cse_pkg.sv
hw/rtl/cse_score_unit.sv
hw/rtl/centered_score_engine_core.sv
tb/sv/tb_centered_score_engine_core.sv
